[rtl/pi_controller_two_form_defines.svh]
// ---------------------------------------------------------------------------
// pi_controller_two_form_defines : assertion macros
// Concurrent check macros shared by the PI controller RTL; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef PI_CONTROLLER_TWO_FORM_DEFINES_SVH
`define PI_CONTROLLER_TWO_FORM_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PI2F_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PI2F_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define PI2F_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PI2F_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/pi2f_pkg.sv]
// ---------------------------------------------------------------------------
// pi2f_pkg : shared types of the two-form PI controller
// Register indices, product selectors and controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none

package pi2f_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORM_SELECT   = 3'd0,
        CFG_PROP_GAIN     = 3'd1,
        CFG_INTEG_GAIN    = 3'd2,
        CFG_SAMPLE_PERIOD = 3'd3,
        CFG_OUT_UPPER     = 3'd4,
        CFG_OUT_LOWER     = 3'd5,
        CFG_INTEG_UPPER   = 3'd6,
        CFG_INTEG_LOWER   = 3'd7
    } t_cfg_idx;

    // Which product the shared multiplier is working on.
    typedef enum logic [1:0] {
        PROD_COEF  = 2'd0,
        PROD_PROP  = 2'd1,
        PROD_INTEG = 2'd2
    } t_prod;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       mul;
        logic [1:0] phase;
        logic       rnd;
        logic       sgn;
        logic       integ;
        logic       iclamp;
        logic       pre;
        logic       drv;
        logic       commit;
        t_prod      prod;
    } t_dp_cmd;

    typedef struct packed {
        logic form;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/pi2f_if.sv]
// ---------------------------------------------------------------------------
// pi2f_if : stream interfaces of the PI controller
// Input channel carries step/clear items, output channel carries results.
// ---------------------------------------------------------------------------
`default_nettype none

interface pi2f_in_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [DATA_WIDTH-1:0] reference;
    logic signed [DATA_WIDTH-1:0] feedback;

    modport source (output valid, opcode, reference, feedback, input ready);
    modport sink   (input valid, opcode, reference, feedback, output ready);
endinterface

interface pi2f_out_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;
    logic signed [DATA_WIDTH-1:0] drive_unclamped;
    logic signed [DATA_WIDTH-1:0] p_term;
    logic signed [DATA_WIDTH-1:0] i_term;
    logic signed [DATA_WIDTH-1:0] error_now;
    logic                         limited;

    modport source (output valid, drive, drive_unclamped, p_term, i_term, error_now,
                    limited, input ready);
    modport sink   (input valid, drive, drive_unclamped, p_term, i_term, error_now,
                    limited, output ready);
endinterface

`default_nettype wire

[rtl/pi2f_mul.sv]
// ---------------------------------------------------------------------------
// pi2f_mul : shared magnitude multiplier
// Half-width multiplier summing four partial products into an accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module pi2f_mul #(
    parameter int OP_WIDTH = 33
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [1:0]            i_phase,
    input  wire logic [OP_WIDTH-1:0]   i_ma,
    input  wire logic [OP_WIDTH-1:0]   i_mb,
    output logic      [2*OP_WIDTH-1:0] o_acc
);

    localparam int H = (OP_WIDTH + 1) / 2;

    logic [H-1:0]          a_sel;
    logic [H-1:0]          b_sel;
    logic [2*H-1:0]        pp;
    logic [2*OP_WIDTH-1:0] pp_sh;
    logic [2*OP_WIDTH-1:0] r_acc;

    // Phase bit 1 picks the upper half of a, bit 0 the upper half of b.
    assign a_sel = i_phase[1] ? H'(i_ma[OP_WIDTH-1:H]) : i_ma[H-1:0];
    assign b_sel = i_phase[0] ? H'(i_mb[OP_WIDTH-1:H]) : i_mb[H-1:0];
    assign pp    = (2*H)'(a_sel) * (2*H)'(b_sel);

    always_comb begin
        case (i_phase)
            2'd0:    pp_sh = (2*OP_WIDTH)'(pp);
            2'd3:    pp_sh = (2*OP_WIDTH)'(pp) << (2*H);
            default: pp_sh = (2*OP_WIDTH)'(pp) << H;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= ((i_phase == 2'd0) ? '0 : r_acc) + pp_sh;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

[rtl/pi2f_ctrl.sv]
// ---------------------------------------------------------------------------
// pi2f_ctrl : sequencer of the PI controller
// One-hot state machine issuing datapath commands and owning the handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pi_controller_two_form_defines.svh"

module pi2f_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_clear,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire pi2f_pkg::t_dp_status  i_status,
    output pi2f_pkg::t_dp_cmd          o_cmd
);

    import pi2f_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_LOAD = 10'b0000000010,
        S_MUL  = 10'b0000000100,
        S_RND  = 10'b0000001000,
        S_SGN  = 10'b0000010000,
        S_INT  = 10'b0000100000,
        S_ICL  = 10'b0001000000,
        S_PRE  = 10'b0010000000,
        S_DRV  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_phase, n_phase;
    t_prod      r_prod, n_prod;
    logic       r_ovalid, n_ovalid;
    logic       accept;
    t_dp_cmd    cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_prod    = r_prod;
        cmd       = '0;
        cmd.prod  = r_prod;
        cmd.phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    if (i_in_clear) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_LOAD;
                        n_prod  = i_status.form ? PROD_PROP : PROD_COEF;
                    end
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                n_phase  = 2'd0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_phase = r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                cmd.rnd = 1'b1;
                n_state = S_SGN;
            end
            S_SGN: begin
                cmd.sgn = 1'b1;
                case (r_prod)
                    PROD_COEF: begin
                        n_prod  = PROD_PROP;
                        n_state = S_LOAD;
                    end
                    PROD_PROP: begin
                        n_prod  = PROD_INTEG;
                        n_state = S_LOAD;
                    end
                    default: begin
                        n_state = S_INT;
                    end
                endcase
            end
            S_INT: begin
                cmd.integ = 1'b1;
                n_state   = S_ICL;
            end
            S_ICL: begin
                cmd.iclamp = 1'b1;
                n_state    = S_PRE;
            end
            S_PRE: begin
                cmd.pre = 1'b1;
                n_state = S_DRV;
            end
            S_DRV: begin
                cmd.drv = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (cmd.commit) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 2'd0;
            r_prod   <= PROD_COEF;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_prod   <= n_prod;
            r_ovalid <= n_ovalid;
        end
    end

    `PI2F_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_in_ready)
    `PI2F_ASSERT_NXT(a_commit_shows_result, i_clk, i_rst_n, cmd.commit, o_out_valid && o_in_ready)
    `PI2F_ASSERT_IMP(a_phase_idle, i_clk, i_rst_n, r_state != S_MUL, r_phase == 2'd0)

endmodule

`default_nettype wire

[rtl/pi2f_dpath.sv]
// ---------------------------------------------------------------------------
// pi2f_dpath : datapath of the PI controller
// Configuration, loop state, operand selection, rounding and clamping.
// ---------------------------------------------------------------------------
`default_nettype none

module pi2f_dpath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [pi2f_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [DATA_WIDTH-1:0]               i_cfg_data,
    input  wire logic                                i_opcode,
    input  wire logic signed [DATA_WIDTH-1:0]        i_reference,
    input  wire logic signed [DATA_WIDTH-1:0]        i_feedback,
    input  wire pi2f_pkg::t_dp_cmd                   i_cmd,
    output pi2f_pkg::t_dp_status                     o_status,
    output logic signed [DATA_WIDTH-1:0]             o_drive,
    output logic signed [DATA_WIDTH-1:0]             o_drive_unclamped,
    output logic signed [DATA_WIDTH-1:0]             o_p_term,
    output logic signed [DATA_WIDTH-1:0]             o_i_term,
    output logic signed [DATA_WIDTH-1:0]             o_error_now,
    output logic                                     o_limited
);

    import pi2f_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int E = DATA_WIDTH + 1;
    localparam logic signed [W-1:0] MAX_V  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_V  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_V  = W'(1) << FRAC_BITS;
    localparam logic [2*E:0]        HALF_F = (2*E+1)'(1) << (FRAC_BITS - 1);
    localparam logic [2*E:0]        HALF_G = (2*E+1)'(1) << FRAC_BITS;

    function automatic logic signed [E-1:0] sx(input logic signed [W-1:0] x);
        sx = {x[W-1], x};
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [E-1:0] x);
        if (x[E-1] != x[E-2]) begin
            sat_w = x[E-1] ? MIN_V : MAX_V;
        end else begin
            sat_w = x[W-1:0];
        end
    endfunction

    function automatic logic [E-1:0] mag(input logic signed [E-1:0] x);
        mag = x[E-1] ? E'(-x) : E'(x);
    endfunction

    // Configuration registers
    logic                  r_form;
    logic signed [W-1:0]   r_kp, r_ki, r_ou, r_ol, r_iu, r_il;
    logic        [W-2:0]   r_ts;

    // Loop state
    logic signed [W-1:0]   r_eprev, r_dly, r_iacc, r_dprev;

    // Working registers
    logic                  r_clr;
    logic signed [W-1:0]   r_err;
    logic signed [E-1:0]   r_diff, r_esum;
    logic        [E-1:0]   r_ma, r_mb;
    logic                  r_neg, r_sh1;
    logic        [2*E:0]   r_rsum;
    logic signed [W-1:0]   r_c, r_p, r_ip;
    logic signed [W-1:0]   r_iraw, r_integ, r_pre, r_drive;
    logic                  r_hit;

    // Result registers
    logic signed [W-1:0]   r_o_drive, r_o_pre, r_o_p, r_o_i, r_o_err;
    logic                  r_o_hit;

    logic signed [E-1:0]   op_a, op_b;
    logic                  op_sh1;
    logic        [2*E-1:0] acc;
    logic        [2*E:0]   shifted;
    logic        [W-1:0]   lim, mag_sat;
    logic signed [W-1:0]   prod_res;
    logic signed [E-1:0]   integ_sum;

    assign o_status.form = r_form;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form <= 1'b0;
            r_kp   <= ONE_V;
            r_ki   <= '0;
            r_ts   <= '0;
            r_ou   <= MAX_V;
            r_ol   <= MIN_V;
            r_iu   <= MAX_V;
            r_il   <= MIN_V;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FORM_SELECT:   r_form <= i_cfg_data[0];
                CFG_PROP_GAIN:     r_kp   <= i_cfg_data;
                CFG_INTEG_GAIN:    r_ki   <= i_cfg_data;
                CFG_SAMPLE_PERIOD: r_ts   <= i_cfg_data[W-2:0];
                CFG_OUT_UPPER:     r_ou   <= i_cfg_data;
                CFG_OUT_LOWER:     r_ol   <= i_cfg_data;
                CFG_INTEG_UPPER:   r_iu   <= i_cfg_data;
                CFG_INTEG_LOWER:   r_il   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Operand selection for the product under way
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sh1 = 1'b0;
        case (i_cmd.prod)
            PROD_COEF: begin
                op_a = E'(r_ts);
                op_b = sx(r_ki);
            end
            PROD_PROP: begin
                op_a = sx(r_kp);
                op_b = r_form ? sx(r_err) : r_diff;
            end
            PROD_INTEG: begin
                if (r_form) begin
                    op_a = sx(r_ki);
                    op_b = sx(r_dly);
                end else begin
                    // The half of the trapezoid is one more dropped bit.
                    op_a   = sx(r_c);
                    op_b   = r_esum;
                    op_sh1 = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    pi2f_mul #(
        .OP_WIDTH (E)
    ) u_mul (
        .i_clk   (i_clk),
        .i_en    (i_cmd.mul),
        .i_phase (i_cmd.phase),
        .i_ma    (r_ma),
        .i_mb    (r_mb),
        .o_acc   (acc)
    );

    // Rounded magnitude, saturated to the largest value of the result's sign
    assign shifted  = r_sh1 ? (r_rsum >> (FRAC_BITS + 1)) : (r_rsum >> FRAC_BITS);
    assign lim      = W'(MAX_V) + W'(r_neg);
    assign mag_sat  = (shifted > (2*E+1)'(lim)) ? lim : shifted[W-1:0];
    assign prod_res = r_neg ? W'(~mag_sat + W'(1)) : mag_sat;

    assign integ_sum = sx(r_ip) + (r_form ? sx(r_iacc) : sx(r_dprev));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_clr <= i_opcode;
            r_err <= sat_w(sx(i_reference) - sx(i_feedback));
        end
        r_diff <= sx(r_err) - sx(r_eprev);
        r_esum <= sx(r_err) + sx(r_eprev);
        if (i_cmd.load) begin
            r_ma  <= mag(op_a);
            r_mb  <= mag(op_b);
            r_neg <= op_a[E-1] ^ op_b[E-1];
            r_sh1 <= op_sh1;
        end
        if (i_cmd.rnd) begin
            r_rsum <= {1'b0, acc} + (r_sh1 ? HALF_G : HALF_F);
        end
        if (i_cmd.sgn) begin
            case (i_cmd.prod)
                PROD_COEF: r_c  <= prod_res;
                PROD_PROP: r_p  <= prod_res;
                default:   r_ip <= prod_res;
            endcase
        end
        if (i_cmd.integ) begin
            r_iraw <= sat_w(integ_sum);
        end
        if (i_cmd.iclamp) begin
            if (r_form && (r_iraw > r_iu)) begin
                r_integ <= r_iu;
            end else if (r_form && (r_iraw < r_il)) begin
                r_integ <= r_il;
            end else begin
                r_integ <= r_iraw;
            end
        end
        if (i_cmd.pre) begin
            r_pre <= sat_w(sx(r_p) + sx(r_integ));
        end
        if (i_cmd.drv) begin
            // When the limits are crossed, values above the upper limit take it; all others take the lower one.
            if (r_pre > r_ou) begin
                r_drive <= r_ou;
                r_hit   <= 1'b1;
            end else if (r_pre < r_ol) begin
                r_drive <= r_ol;
                r_hit   <= 1'b1;
            end else begin
                r_drive <= r_pre;
                r_hit   <= 1'b0;
            end
        end
        if (i_cmd.commit) begin
            if (r_clr) begin
                r_o_drive <= '0;
                r_o_pre   <= '0;
                r_o_p     <= '0;
                r_o_i     <= '0;
                r_o_err   <= '0;
                r_o_hit   <= 1'b0;
            end else begin
                r_o_drive <= r_drive;
                r_o_pre   <= r_pre;
                r_o_p     <= r_p;
                r_o_i     <= r_integ;
                r_o_err   <= r_err;
                r_o_hit   <= r_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eprev <= '0;
            r_dly   <= '0;
            r_iacc  <= '0;
            r_dprev <= '0;
        end else if (i_cmd.commit) begin
            if (r_clr) begin
                r_eprev <= '0;
                r_dly   <= '0;
                r_iacc  <= '0;
                r_dprev <= '0;
            end else begin
                r_iacc  <= r_integ;
                r_dprev <= r_drive;
                if (r_form) begin
                    r_dly <= r_err;
                end else begin
                    r_dly   <= r_p;
                    r_eprev <= r_err;
                end
            end
        end
    end

    assign o_drive           = r_o_drive;
    assign o_drive_unclamped = r_o_pre;
    assign o_p_term          = r_o_p;
    assign o_i_term          = r_o_i;
    assign o_error_now       = r_o_err;
    assign o_limited         = r_o_hit;

endmodule

`default_nettype wire

[rtl/pi_controller_two_form.sv]
// ---------------------------------------------------------------------------
// pi_controller_two_form : discrete PI regulator with output saturation
// Signed fixed-point PI controller with incremental and difference forms.
// ---------------------------------------------------------------------------
// Usage. Each input transaction on i_in carries an opcode, a reference and a
// feedback sample; every input transaction gives exactly one output
// transaction on o_out. Opcode 0 runs one control step, opcode 1 clears the
// loop state and returns a result with all fields zero. The gains, the sample
// period and the limits are written through the plain write port (i_cfg_we,
// i_cfg_idx, i_cfg_data); the user must do so only while the block is idle,
// which the block itself does not enforce. A control step uses the single
// shared multiplier once per product: three products in the incremental form
// and two in the difference form, none for a clear. Each product takes
// operand preparation, four half-width partial products, rounding and
// applying the sign; summing and clamping the integral and then the drive
// follow. The input is ready only while the block is idle, so a new input
// transaction is taken only after the previous result has been registered.
// The result sits in an output register, so a following input transaction is
// accepted while the receiver stalls; only the register write of the next
// result waits until the previous one has been taken.
// Reset (synchronous, active low) clears the loop state, restores the
// register defaults and drops o_out.valid.
// ---------------------------------------------------------------------------
`default_nettype none

module pi_controller_two_form #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    pi2f_in_if.sink                              i_in,
    pi2f_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [pi2f_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [DATA_WIDTH-1:0]           i_cfg_data
);

    import pi2f_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    t_dp_cmd    cmd;
    t_dp_status status;

    pi2f_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_clear  (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, the loop state and the result
    // register; its loop state and result change only on the sequencer's commands.
    pi2f_dpath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_in.opcode),
        .i_reference       (i_in.reference),
        .i_feedback        (i_in.feedback),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_drive           (o_out.drive),
        .o_drive_unclamped (o_out.drive_unclamped),
        .o_p_term          (o_out.p_term),
        .o_i_term          (o_out.i_term),
        .o_error_now       (o_out.error_now),
        .o_limited         (o_out.limited)
    );

endmodule

`default_nettype wire
